### rtl/mrr_pkg.sv
// Package for the Miller-Rabin round unit: payload structs and sizing constants.
// Used by every module under rtl; depends on nothing.
package mrr_pkg;
    localparam int unsigned ValueWidthDefault = 32;
    localparam int unsigned CandWidth = 32;
    localparam int unsigned RandWidth = 31;

    typedef struct packed {
        logic [CandWidth-1:0] candidate;
        logic [RandWidth-1:0] random_word;
    } t_in_item;

    typedef struct packed {
        logic                 probably_prime;
        logic [RandWidth-1:0] witness_used;
    } t_out_item;
endpackage

### rtl/mrr_modmul.sv
// Bit-serial modular multiplier: one bit of the multiplier per cycle, MSB first.
// Uses mrr_pkg for the default of W; leaf module.
module mrr_modmul #(
    parameter int unsigned W = mrr_pkg::ValueWidthDefault
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_x,
    input  logic [W-1:0] i_y,
    input  logic [W-1:0] i_m,
    output logic         o_done,
    output logic [W-1:0] o_p
);
    import mrr_pkg::*;
    localparam int unsigned CW = $clog2(W + 1);

    logic [W-1:0]  r_acc, n_acc;
    logic [W-1:0]  r_y;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [W:0]    dbl, dbl_r, add, add_r;

    // Each step: acc = 2*acc mod m, then add x mod m when the current bit is set.
    always_comb begin
        dbl   = {r_acc, 1'b0};
        dbl_r = (dbl >= {1'b0, i_m}) ? dbl - {1'b0, i_m} : dbl;
        add   = dbl_r + {1'b0, i_x};
        add_r = (add >= {1'b0, i_m}) ? add - {1'b0, i_m} : add;
        n_acc = r_y[W-1] ? add_r[W-1:0] : dbl_r[W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W);
                r_acc  <= '0;
                r_y    <= i_y;
            end else if (r_busy) begin
                r_acc <= n_acc;
                r_y   <= {r_y[W-2:0], 1'b0};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_p    = r_acc;
endmodule

### rtl/mrr_modred.sv
// Restoring bit-serial reducer: computes i_a mod i_m one dividend bit per cycle.
// Leaf module; imports mrr_pkg by convention.
module mrr_modred #(
    parameter int unsigned W  = mrr_pkg::ValueWidthDefault,
    parameter int unsigned AW = mrr_pkg::RandWidth
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [AW-1:0] i_a,
    input  logic [W-1:0]  i_m,
    output logic          o_done,
    output logic [W-1:0]  o_r
);
    import mrr_pkg::*;
    localparam int unsigned CW = $clog2(AW + 1);

    logic [W-1:0]  r_rem;
    logic [AW-1:0] r_a;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [W:0]    sh, sub;

    always_comb begin
        sh  = {r_rem, r_a[AW-1]};
        sub = sh - {1'b0, i_m};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(AW);
                r_rem  <= '0;
                r_a    <= i_a;
            end else if (r_busy) begin
                r_rem <= sub[W] ? sh[W-1:0] : sub[W-1:0];
                r_a   <= {r_a[AW-2:0], 1'b0};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_r    = r_rem;
endmodule

### rtl/miller_rabin_round_unit.sv
// Top level of the Miller-Rabin round unit: screening, sequencing, output register.
// Depends on mrr_pkg, mrr_modred and mrr_modmul.
//
// One item at a time. An item settled by screening (negative, below 2, even) passes
// through StOut to the output register. Otherwise the witness reduction walks the
// 31 bits of the random word, while n-1 is split into d*2^s one bit per cycle.
// Each modular multiplication is done bit-serially; the exponentiation and the
// squarings together need at most 2*(W-1) of them. The multiplier sets the rate.
module miller_rabin_round_unit #(
    parameter int unsigned VALUE_WIDTH = mrr_pkg::ValueWidthDefault
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  mrr_pkg::t_in_item i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output mrr_pkg::t_out_item o_data
);
    import mrr_pkg::*;
    localparam int unsigned W  = VALUE_WIDTH;
    localparam int unsigned SW = $clog2(W + 1);

    localparam logic [2:0] StIdle = 3'd0;
    localparam logic [2:0] StRed  = 3'd1;
    localparam logic [2:0] StExp  = 3'd2;
    localparam logic [2:0] StSq   = 3'd3;
    localparam logic [2:0] StOut  = 3'd4;
    localparam logic [2:0] StWait = 3'd5;

    logic [2:0]    r_state;
    logic [W-1:0]  r_n, r_d, r_acc, r_sq, r_x;
    logic [RandWidth-1:0] r_rnd;
    logic [SW-1:0] r_s;
    logic          r_phase; // 0: acc*sq, 1: sq*sq during exponentiation
    logic          r_mul_busy;
    logic [W-1:0]  r_wit;
    logic          r_pass;
    logic          r_ovalid;
    t_out_item     r_out;

    logic          red_start, red_done;
    logic [RandWidth-1:0] red_a;
    logic [W-1:0]  red_r;
    logic          mul_start, mul_done;
    logic [W-1:0]  mul_x, mul_y, mul_p;

    logic [W-1:0]  v;
    logic          accept;

    assign v      = i_data.candidate[W-1:0];
    assign accept = i_valid && o_ready;
    assign o_ready = (r_state == StIdle) && !r_ovalid;

    // The random word is latched in r_rnd until the reducer starts.
    assign red_a = r_rnd;

    mrr_modred #(.W(W), .AW(RandWidth)) u_red (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(red_start), .i_a(red_a),
        .i_m(r_n - W'(2)), .o_done(red_done), .o_r(red_r)
    );

    mrr_modmul #(.W(W)) u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(mul_start), .i_x(mul_x),
        .i_y(mul_y), .i_m(r_n), .o_done(mul_done), .o_p(mul_p)
    );

    assign red_start = (r_state == StRed) && !r_mul_busy;
    assign mul_start = !r_mul_busy && ((r_state == StSq) ||
                       ((r_state == StExp) && (r_d != '0) && (r_phase || r_d[0])));

    always_comb begin
        if (r_state == StSq) begin
            mul_x = r_x;
            mul_y = r_x;
        end else if (!r_phase) begin
            mul_x = r_acc;
            mul_y = r_sq;
        end else begin
            mul_x = r_sq;
            mul_y = r_sq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= StIdle;
            r_ovalid   <= 1'b0;
            r_mul_busy <= 1'b0;
            r_phase    <= 1'b0;
        end else begin
            if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                StIdle: begin
                    if (accept) begin
                        r_n    <= v;
                        r_rnd  <= i_data.random_word;
                        r_wit  <= '0;
                        r_pass <= 1'b0;
                        if (v[W-1] || v < W'(2) || !v[0]) begin
                            r_pass  <= (v == W'(2));
                            r_state <= StOut;
                        end else begin
                            r_state <= StRed;
                        end
                    end
                end
                StRed: begin
                    // The reducer runs while r_mul_busy marks it as started.
                    // Meanwhile n-1 is halved once per cycle until it is odd; the
                    // reducer takes longer than the largest possible s.
                    if (!r_mul_busy) begin
                        r_mul_busy <= 1'b1;
                        r_s        <= '0;
                        r_d        <= r_n - W'(1);
                    end else begin
                        if (!r_d[0]) begin
                            r_d <= r_d >> 1;
                            r_s <= r_s + SW'(1);
                        end
                        if (red_done) begin
                            r_mul_busy <= 1'b0;
                            r_wit      <= red_r + W'(2);
                            r_sq       <= red_r + W'(2);
                            r_acc      <= W'(1);
                            r_phase    <= 1'b0;
                            r_state    <= StExp;
                        end
                    end
                end
                StExp: begin
                    if (!r_mul_busy) begin
                        if (r_d == '0) begin
                            r_x     <= r_acc;
                            r_pass  <= (r_acc == W'(1));
                            r_state <= StWait;
                        end else if (!r_phase && !r_d[0]) begin
                            r_phase <= 1'b1;
                        end else begin
                            r_mul_busy <= 1'b1;
                        end
                    end else if (mul_done) begin
                        r_mul_busy <= 1'b0;
                        if (!r_phase) begin
                            r_acc   <= mul_p;
                            r_phase <= 1'b1;
                        end else begin
                            r_sq    <= mul_p;
                            r_d     <= r_d >> 1;
                            r_phase <= 1'b0;
                        end
                    end
                end
                StWait: begin
                    if (r_pass || r_s == '0) begin
                        r_state <= StOut;
                    end else if (r_x == r_n - W'(1)) begin
                        r_pass  <= 1'b1;
                        r_state <= StOut;
                    end else begin
                        r_state <= StSq;
                    end
                end
                StSq: begin
                    if (!r_mul_busy) begin
                        r_mul_busy <= 1'b1;
                    end else if (mul_done) begin
                        r_mul_busy <= 1'b0;
                        r_x        <= mul_p;
                        r_s        <= r_s - 1'b1;
                        r_state    <= StWait;
                    end
                end
                StOut: begin
                    if (!r_ovalid) begin
                        r_ovalid                <= 1'b1;
                        r_out.probably_prime    <= r_pass;
                        r_out.witness_used      <= RandWidth'(r_wit);
                        r_state                 <= StIdle;
                    end
                end
                default: r_state <= StIdle;
            endcase
        end
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_out;

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != StIdle) |-> !o_ready) else $error("ready while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_data)))
        else $error("result dropped");
    a_screen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_data.probably_prime && o_data.witness_used == '0)
        |-> (r_state == StIdle)) else $error("state after screening");
`endif
endmodule

### test/testbench.sv
// Testbench for the Miller-Rabin round unit: screening verdicts and full rounds
// checked against a behavioral predictor. Depends on mrr_pkg and the RTL top level.
module testbench;
    import mrr_pkg::*;

    localparam int unsigned VW = 32;
    localparam int unsigned IDLE_LIMIT = 20000;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_ready;
    t_in_item  i_data;
    logic      o_valid;
    logic      i_ready;
    t_out_item o_data;

    t_in_item  pending_items[$];
    t_out_item verdicts_due[$];
    int        fail_count;
    int        idle_cycles;
    int        burst_left;
    int        gap_left;
    int        stall_phase;
    bit        stim_done;

    miller_rabin_round_unit #(.VALUE_WIDTH(VW)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_data(i_data), .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    function automatic logic [63:0] mul_mod(logic [63:0] x, logic [63:0] y, logic [63:0] m);
        return (x * y) % m;
    endfunction

    function automatic t_out_item round_verdict(t_in_item item);
        t_out_item res;
        logic [63:0] n, d, x, wit, acc, sq, e;
        int s;
        bit pass;
        res = '0;
        n = {32'b0, item.candidate};
        if (n[VW-1] || n < 2) return res;
        if (n == 2) begin
            res.probably_prime = 1'b1;
            return res;
        end
        if (!n[0]) return res;
        d = n - 1;
        s = 0;
        while (!d[0]) begin
            d = d >> 1;
            s++;
        end
        wit = 2 + ({33'b0, item.random_word} % (n - 2));
        acc = 1;
        sq = wit % n;
        e = d;
        while (e != 0) begin
            if (e[0]) acc = mul_mod(acc, sq, n);
            sq = mul_mod(sq, sq, n);
            e = e >> 1;
        end
        x = acc;
        pass = (x == 1);
        for (int r = 0; !pass && r < s; r++) begin
            if (x == n - 1) pass = 1'b1;
            else x = mul_mod(x, x, n);
        end
        res.probably_prime = pass;
        res.witness_used = wit[30:0];
        return res;
    endfunction

    task automatic add_item(logic [31:0] cand, logic [30:0] rnd);
        t_in_item item;
        item.candidate = cand;
        item.random_word = rnd;
        pending_items.push_back(item);
    endtask

    initial begin
        logic [31:0] c;
        int pick;
        // Extremes and screening cases first.
        add_item(32'h8000_0000, 31'h7FFF_FFFF);
        add_item(32'hFFFF_FFFF, 31'd0);
        add_item(32'd0, 31'd5);
        add_item(32'd1, 31'h7FFF_FFFF);
        add_item(32'd2, 31'd123);
        add_item(32'd3, 31'h7FFF_FFFF);
        add_item(32'd3, 31'd0);
        add_item(32'd4, 31'd9);
        add_item(32'h7FFF_FFFE, 31'd1);
        add_item(32'h7FFF_FFFF, 31'h7FFF_FFFF);
        add_item(32'h7FFF_FFFF, 31'd0);
        add_item(32'd5, 31'd2);
        add_item(32'd561, 31'd40);
        add_item(32'd341, 31'd0);
        add_item(32'd2047, 31'd0);
        add_item(32'd65537, 31'h5555_5555);
        add_item(32'h7FFF_FFED, 31'h2AAA_AAAA);
        add_item(32'd9, 31'd6);
        add_item(32'h7FFF_FFFD, 31'h7FFF_FFFE);
        for (int k = 0; k < 121; k++) begin
            pick = $urandom_range(0, 9);
            c = $urandom;
            if (pick < 6) c = {1'b0, c[30:1], 1'b1};
            else if (pick == 6) c = {24'b0, c[7:1], 1'b1};
            else if (pick == 7) c[0] = 1'b0;
            add_item(c, 31'($urandom));
        end
        fail_count = 0;
        stim_done = 1'b0;
        i_rst_n = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_items.size() == 0 && !i_valid);
        stim_done = 1'b1;
    end

    // Sender: bursts of random length separated by random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_data <= '0;
            burst_left <= $urandom_range(1, 4);
            gap_left <= 0;
        end else if (!i_valid || o_ready) begin
            if (i_valid) begin
                verdicts_due.push_back(round_verdict(i_data));
            end
            if (gap_left > 0 || pending_items.size() == 0) begin
                i_valid <= 1'b0;
                if (gap_left > 0) gap_left <= gap_left - 1;
            end else begin
                i_valid <= 1'b1;
                i_data <= pending_items.pop_front();
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 6);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // Receiver stalls on a rotating pattern plus random stalls, except while stall_phase[8] is set.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            stall_phase <= 0;
        end else begin
            stall_phase <= stall_phase + 1;
            if (stall_phase[8]) i_ready <= 1'b1;
            else i_ready <= (stall_phase % 7 != 3) && ($urandom_range(0, 4) != 0);
        end
    end

    // Monitor and watchdog.
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            if ((o_valid && i_ready) || (i_valid && o_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (o_valid && i_ready) begin
                if (verdicts_due.size() == 0) begin
                    $display("%0t: unexpected result, actual %h", $time, o_data);
                    fail_count++;
                end else begin
                    want = verdicts_due.pop_front();
                    if (want.probably_prime !== o_data.probably_prime) begin
                        $display("%0t: probably_prime expected %b actual %b", $time,
                                 want.probably_prime, o_data.probably_prime);
                        fail_count++;
                    end
                    if (want.witness_used !== o_data.witness_used) begin
                        $display("%0t: witness_used expected %0d actual %0d", $time,
                                 want.witness_used, o_data.witness_used);
                        fail_count++;
                    end
                end
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        wait (stim_done === 1'b1 && verdicts_due.size() == 0);
        repeat (50) @(posedge i_clk);
        if (fail_count == 0 && verdicts_due.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
